[rtl/core/ibs_pkg.sv]
// shared types and constants for the integer byte serializer
package ibs_pkg;

    localparam int VALUE_W    = 64;
    localparam int CMD_W      = 3;
    localparam int BYTE_W     = 8;
    localparam int GROUP_W    = 7;
    localparam int CNT_W      = 3;
    localparam int S_TDATA_W  = ((CMD_W + VALUE_W + 7) / 8) * 8;
    localparam int S_PAD_W    = S_TDATA_W - CMD_W - VALUE_W;
    localparam int M_TDATA_W  = BYTE_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_U8     = 3'd0,
        CMD_U16    = 3'd1,
        CMD_U32    = 3'd2,
        CMD_U64    = 3'd3,
        CMD_VARINT = 3'd4,
        CMD_ZIGZAG = 3'd5
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // sequencer to datapath controls
    typedef struct packed {
        logic             load;
        logic             advance;
        logic             varint;
        logic [CNT_W-1:0] cnt;
    } ctrl_t;

endpackage

[rtl/core/ibs_step_unit.sv]
// shared step unit: forms one output byte and the shifted remainder
module ibs_step_unit (
    input  logic [ibs_pkg::VALUE_W-1:0] data,
    input  logic                        varint,
    input  logic [ibs_pkg::CNT_W-1:0]   cnt,
    output logic [ibs_pkg::BYTE_W-1:0]  out_byte,
    output logic                        last,
    output logic [ibs_pkg::VALUE_W-1:0] data_next
);
    import ibs_pkg::*;

    logic [VALUE_W-GROUP_W-1:0] rest;

    assign rest = data[VALUE_W-1:GROUP_W];

    always_comb
    begin
        if (varint)
        begin
            // low 7 bits first, continuation flag while bits remain
            last      = (rest == '0);
            out_byte  = {~last, data[GROUP_W-1:0]};
            data_next = {{GROUP_W{1'b0}}, rest};
        end
        else
        begin
            // most significant byte sits at the top
            last      = (cnt == '0);
            out_byte  = data[VALUE_W-1:VALUE_W-BYTE_W];
            data_next = {data[VALUE_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
        end
    end

endmodule

[rtl/core/ibs_seq.sv]
// sequencer: accepts a command and steps the shared unit once per byte
module ibs_seq (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_fire,
    input  logic [ibs_pkg::CMD_W-1:0] cmd,
    input  logic                      out_free,
    input  logic                      step_last,
    output logic                      idle,
    output ibs_pkg::ctrl_t            ctrl
);
    import ibs_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             varint_reg, varint_next;
    logic             cmd_ok;

    assign cmd_ok = (cmd == CMD_U8) || (cmd == CMD_U16) || (cmd == CMD_U32)
                 || (cmd == CMD_U64) || (cmd == CMD_VARINT) || (cmd == CMD_ZIGZAG);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            varint_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            varint_reg <= varint_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        varint_next  = varint_reg;
        idle         = 1'b0;
        ctrl.load    = 1'b0;
        ctrl.advance = 1'b0;
        ctrl.varint  = varint_reg;
        ctrl.cnt     = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                if (s_fire && cmd_ok)
                begin
                    ctrl.load   = 1'b1;
                    state_next  = ST_RUN;
                    varint_next = (cmd == CMD_VARINT) || (cmd == CMD_ZIGZAG);
                    unique case (cmd)
                        CMD_U16: cnt_next = CNT_W'(1);
                        CMD_U32: cnt_next = CNT_W'(3);
                        CMD_U64: cnt_next = CNT_W'(7);
                        default: cnt_next = '0;
                    endcase
                end
            end
            ST_RUN:
            begin
                if (out_free)
                begin
                    ctrl.advance = 1'b1;
                    cnt_next     = cnt_reg - CNT_W'(1);
                    if (step_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/integer_byte_serializer.sv]
// top level of the integer byte serializer
//
// usage:
//   s_axis channel: one transfer carries a command and a 64-bit value.
//     commands: u8, u16, u32, u64 (big-endian fixed width, low bits used),
//     unsigned varint (7-bit groups, low group first, bit 7 = more follow)
//     and zigzag varint (sign folded into bit 0 before varint coding).
//     commands 6 and 7 are accepted and dropped without output.
//   m_axis channel: one transfer per encoded byte, tlast on the final byte.
// throughput:
//   the input transfer loads the working word; each step then registers
//   one byte per cycle while the output register is free; an item is 1 to
//   10 bytes, formed by the single shift/compare step unit.
//   s_axis_tready is high only while no item is being encoded.
// reset:
//   rst_n clears the sequencer and the output valid; no item is in flight.
// stalls:
//   while m_axis_tready is low the output register holds its byte and the
//   sequencer waits; no byte is lost or repeated.
module integer_byte_serializer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [2:0] cmd, [66:3] value, [71:67] zero padding
    input  logic [ibs_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] out_byte
    output logic [ibs_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast
);
    import ibs_pkg::*;

    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    logic [S_PAD_W-1:0] pad_unused;

    ctrl_t              ctrl;
    logic               idle;
    logic               s_fire;
    logic               out_free;

    // working word, shifted one byte or group per step
    logic [VALUE_W-1:0] data_reg, data_next;
    logic [VALUE_W-1:0] data_load;
    logic [VALUE_W-1:0] step_data;
    logic [BYTE_W-1:0]  step_byte;
    logic               step_last;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]  m_byte_reg, m_byte_next;
    logic               m_last_reg, m_last_next;

    assign cmd        = s_axis_tdata[CMD_W-1:0];
    assign value      = s_axis_tdata[CMD_W+VALUE_W-1:CMD_W];
    assign pad_unused = s_axis_tdata[S_TDATA_W-1:CMD_W+VALUE_W];

    assign s_axis_tready = idle;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    ibs_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_fire    (s_fire),
        .cmd       (cmd),
        .out_free  (out_free),
        .step_last (step_last),
        .idle      (idle),
        .ctrl      (ctrl)
    );

    ibs_step_unit u_step (
        .data      (data_reg),
        .varint    (ctrl.varint),
        .cnt       (ctrl.cnt),
        .out_byte  (step_byte),
        .last      (step_last),
        .data_next (step_data)
    );

    // align fixed-width data to the top, fold the sign for zigzag
    always_comb
    begin
        unique case (cmd)
            CMD_U8:     data_load = {value[7:0],  {(VALUE_W-8){1'b0}}};
            CMD_U16:    data_load = {value[15:0], {(VALUE_W-16){1'b0}}};
            CMD_U32:    data_load = {value[31:0], {(VALUE_W-32){1'b0}}};
            CMD_ZIGZAG: data_load = {value[VALUE_W-2:0], 1'b0}
                                  ^ {VALUE_W{value[VALUE_W-1]}};
            default:    data_load = value;
        endcase
    end

    always_comb
    begin
        data_next    = data_reg;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_valid_reg;
        if (m_axis_tready)
            m_valid_next = 1'b0;
        if (ctrl.load)
            data_next = data_load;
        else if (ctrl.advance)
        begin
            data_next    = step_data;
            m_byte_next  = step_byte;
            m_last_next  = step_last;
            m_valid_next = 1'b1;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_byte_reg;
    // padding bits carry nothing; fold them into an unused term
    assign m_axis_tlast  = m_last_reg | (1'b0 & (|pad_unused));

endmodule

[tb/tb_integer_byte_serializer.sv]
// self-checking testbench for the integer byte serializer
module tb_integer_byte_serializer;

    import ibs_pkg::*;

    // run length and stall settings
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ITEMS  = 150;     // per phase, three phases
    localparam int HOLD_CYCLES   = 250;     // long receiver hold-off
    localparam int DRAIN_CYCLES  = 20;      // settle time at the end
    localparam int MAX_REPORTS   = 10;
    localparam int VARINT_GROUP  = 128;

    // command codes the block drops without output
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
    } value_item_t;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
    } coded_byte_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    value_item_t pending_items[$];      // items waiting for the driver
    coded_byte_t coded_bytes[$];        // bytes the encoder should still emit

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  fail_cnt = 0;
    int  cycle_cnt = 0;
    int  hold_left = 0;
    int  hold_req = 0;
    int  hold_served = 0;
    bit  in_taken = 1'b0;
    coded_byte_t want;
    value_item_t drv_item;

    integer_byte_serializer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // expected byte stream for one accepted command/value pair
    function automatic void encode_value(input logic [CMD_W-1:0] cmd,
                                         input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] w;
        int                 nbytes;
        coded_byte_t        b;
        case (cmd)
            CMD_U8, CMD_U16, CMD_U32, CMD_U64:
            begin
                // big-endian, only the low nbytes of value count
                nbytes = 1 << cmd;
                for (int k = 0; k < nbytes; k++)
                begin
                    w      = value >> (8 * (nbytes - 1 - k));
                    b.data = w[BYTE_W-1:0];
                    b.last = (k == nbytes - 1);
                    coded_bytes.push_back(b);
                end
            end
            CMD_VARINT, CMD_ZIGZAG:
            begin
                w = value;
                // zigzag folds the sign into bit 0
                if (cmd == CMD_ZIGZAG)
                    w = (value << 1) ^ {VALUE_W{value[VALUE_W-1]}};
                while (w >= VARINT_GROUP)
                begin
                    b.data = {1'b1, w[GROUP_W-1:0]};
                    b.last = 1'b0;
                    coded_bytes.push_back(b);
                    w = w >> GROUP_W;
                end
                b.data = w[BYTE_W-1:0];
                b.last = 1'b1;
                coded_bytes.push_back(b);
            end
            default:
            begin
                // unused command, nothing comes out
            end
        endcase
    endfunction

    // values spread over all varint lengths and both signs
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            0: ;
            1: v = VALUE_W'($urandom_range(300));
            2: v = -VALUE_W'($urandom_range(300));
            default: v = v >> $urandom_range(VALUE_W - 1);
        endcase
        return v;
    endfunction

    function automatic void add_item(input logic [CMD_W-1:0] cmd,
                                     input logic [VALUE_W-1:0] value);
        value_item_t it;
        it.cmd   = cmd;
        it.value = value;
        pending_items.push_back(it);
    endfunction

    // input side: a new transfer is offered once the last one was taken
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                drv_item = pending_items.pop_front();
                s_axis_tdata  <= {{S_PAD_W{1'b0}}, drv_item.value, drv_item.cmd};
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output side ready, with random idling and the long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    // long hold-off counter, started on request from the stimulus
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_served != hold_req)
        begin
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end
    end

    // input transfers feed the predictor, output transfers get checked
    always @(posedge clk)
    begin
        in_taken = s_axis_tvalid && s_axis_tready;
        if (rst_n && in_taken)
            encode_value(s_axis_tdata[CMD_W-1:0], s_axis_tdata[CMD_W +: VALUE_W]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (coded_bytes.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= MAX_REPORTS)
                    $display("unexpected byte %02h last %0b", m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = coded_bytes.pop_front();
                if (m_axis_tdata !== want.data || m_axis_tlast !== want.last)
                begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                                 want.data, want.last, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 6;  recv_idle_pct = 53; end
                1:       begin send_idle_pct = 53; recv_idle_pct = 6;  end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase

            if (phase == 0)
            begin
                // fixed widths with high bits that must be dropped
                add_item(CMD_U8,  64'hffff_ffff_ffff_ff00);
                add_item(CMD_U8,  64'h0123_4567_89ab_cdff);
                add_item(CMD_U16, 64'hffff_ffff_ffff_0000);
                add_item(CMD_U16, 64'h0000_0000_0000_ffff);
                add_item(CMD_U32, 64'hdead_beef_8000_0001);
                add_item(CMD_U32, 64'h0000_0000_0000_0000);
                add_item(CMD_U64, 64'hffff_ffff_ffff_ffff);
                add_item(CMD_U64, 64'h0102_0304_0506_0708);
                // varint of zero and the group boundaries
                add_item(CMD_VARINT, 64'd0);
                add_item(CMD_VARINT, 64'd127);
                add_item(CMD_VARINT, 64'd128);
                add_item(CMD_VARINT, 64'h7fff_ffff_ffff_ffff);
                add_item(CMD_VARINT, 64'hffff_ffff_ffff_ffff);
                // zigzag around zero and at the signed extremes
                add_item(CMD_ZIGZAG, 64'd0);
                add_item(CMD_ZIGZAG, 64'hffff_ffff_ffff_ffff);
                add_item(CMD_ZIGZAG, 64'd1);
                add_item(CMD_ZIGZAG, 64'h8000_0000_0000_0000);
                add_item(CMD_ZIGZAG, 64'h7fff_ffff_ffff_ffff);
                // unused commands, dropped without output
                add_item(CMD_UNUSED_LO, 64'h5555_aaaa_5555_aaaa);
                add_item(CMD_UNUSED_HI, 64'hffff_ffff_ffff_ffff);
                add_item(CMD_VARINT, 64'd300);
            end
            else if (phase == 2)
            begin
                // receiver stops for a while, encoder fills and blocks input
                hold_req = hold_req + 1;
            end

            for (int n = 0; n < RANDOM_ITEMS; n++)
            begin
                if ($urandom_range(99) < 4)
                    add_item(CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO)),
                             pick_value());
                else
                    add_item(CMD_W'($urandom_range(CMD_ZIGZAG, CMD_U8)), pick_value());
            end

            // look just after the falling edge so the driver's update is visible
            while (pending_items.size() != 0 || s_axis_tvalid || coded_bytes.size() != 0)
            begin
                @(negedge clk);
                #1;
            end
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_cnt == 0 && coded_bytes.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
